>>> design/sall_pkg.sv
// package for the sorted linked list block
// types and codes shared by the controller, the datapath and the top level
package sall_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ELEMENT   = 3'd3,
    ST_EMPTY     = 3'd4
  } res_status_e;

  typedef enum logic [0:0] {
    FN_INSERT = 1'b0,
    FN_DUMP   = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_DUMP,
    S_CMP,
    S_DECIDE,
    S_ALLOC,
    S_LINK,
    S_RESP
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic        load_in;     // capture the input item
    logic        start_walk;  // p from list head, q cleared
    logic        rd_en;       // read the slot at p
    logic        advance;     // q takes p, p takes the next link
    logic        alloc_wr;    // write value and link of the new slot
    logic        link_wr;     // splice the new slot in, advance free head
    logic        emit;        // load the output register
    logic        emit_elem;   // item comes from the read slot
    res_status_e emit_status;
    logic        emit_last;
  } sall_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  head_zero;  // list is empty
    logic  next_zero;  // read slot ends the chain
    logic  less;       // read value below the input value
    logic  equal;      // read value matches the input value
    logic  free_zero;  // no free slot left
    logic  out_free;   // output register can take a result
  } sall_stat_t;

endpackage

>>> design/sall_ctrl.sv
// controller of the sorted linked list block
// sequences list walks, slot allocation and results; uses sall_pkg
module sall_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sall_pkg::sall_stat_t stat_i,
  output sall_pkg::sall_cmd_t  cmd_o
);
  import sall_pkg::*;

  ctrl_state_e state_q, state_d;
  res_status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (stat_i.head_zero) begin
          if (stat_i.func == FN_DUMP) begin
            res_d   = ST_EMPTY;
            state_d = S_RESP;
          end else begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = (stat_i.func == FN_DUMP) ? S_DUMP : S_CMP;
      end
      S_DUMP: begin
        if (stat_i.out_free) state_d = stat_i.next_zero ? S_IDLE : S_READ;
      end
      S_CMP: begin
        if (stat_i.less) begin
          state_d = stat_i.next_zero ? S_DECIDE : S_READ;
        end else if (stat_i.equal) begin
          res_d   = ST_DUPLICATE;
          state_d = S_RESP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.free_zero) begin
          res_d   = ST_FULL;
          state_d = S_RESP;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: state_d = S_LINK;
      S_LINK: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = ST_INSERTED;
    in_ready_o        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_START: cmd_o.start_walk = 1'b1;
      S_READ:  cmd_o.rd_en = 1'b1;
      S_DUMP: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.advance     = stat_i.out_free;
        cmd_o.emit_elem   = 1'b1;
        cmd_o.emit_status = ST_ELEMENT;
        cmd_o.emit_last   = stat_i.next_zero;
      end
      S_CMP:    cmd_o.advance = stat_i.less;
      S_DECIDE: ;
      S_ALLOC:  cmd_o.alloc_wr = 1'b1;
      S_LINK: begin
        cmd_o.link_wr     = stat_i.out_free;
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_status = ST_INSERTED;
        cmd_o.emit_last   = 1'b1;
      end
      S_RESP: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_status = res_q;
        cmd_o.emit_last   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> design/sall_dp.sv
// datapath of the sorted linked list block
// slot memories, walk pointers, list and free heads, output register; uses sall_pkg
module sall_dp #(
  parameter int SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sall_pkg::sall_cmd_t cmd_i,
  output sall_pkg::sall_stat_t stat_o,
  input  logic                func_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic signed [31:0]  item_o,
  output logic                last_o
);
  import sall_pkg::*;

  localparam int LW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  function automatic logic [LW-1:0] clamp_link(input logic [LW-1:0] l);
    return ({1'b0, l} < (LW+1)'(SLOTS)) ? l : '0;
  endfunction

  logic signed [31:0] value_mem [SLOTS];
  logic [LW-1:0]      link_mem  [SLOTS];

  func_e              func_q;
  logic signed [31:0] value_q;
  logic [LW-1:0]      p_q, q_q;
  logic [LW-1:0]      list_head_q, free_head_q;
  logic signed [31:0] rd_value_q;
  logic [LW-1:0]      rd_link_q;
  logic [LW-1:0]      next_link;
  logic [LW:0]        free_inc;
  logic [LW-1:0]      free_next;

  logic               out_valid_q;
  res_status_e        status_q;
  logic signed [31:0] item_q;
  logic               last_q;

  assign next_link = clamp_link(rd_link_q);
  // free slots are handed out in ascending order, so the free chain is a count
  assign free_inc  = {1'b0, free_head_q} + 1'b1;
  assign free_next = (free_inc < (LW+1)'(SLOTS)) ? free_inc[LW-1:0] : '0;

  // slot memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_wr) begin
      value_mem[free_head_q] <= value_q;
    end
    if (cmd_i.alloc_wr) begin
      link_mem[free_head_q] <= p_q;
    end else if (cmd_i.link_wr && q_q != '0) begin
      link_mem[q_q] <= free_head_q;
    end
    if (cmd_i.rd_en) begin
      rd_value_q <= value_mem[p_q];
      rd_link_q  <= link_mem[p_q];
    end
  end

  // item capture and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= func_e'(func_i);
      value_q <= value_i;
    end
    if (cmd_i.start_walk) begin
      p_q <= clamp_link(list_head_q);
      q_q <= '0;
    end else if (cmd_i.advance) begin
      q_q <= p_q;
      p_q <= next_link;
    end
  end

  // list and free heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_head_q <= '0;
      free_head_q <= LW'(1);
    end else if (cmd_i.link_wr) begin
      if (q_q == '0) list_head_q <= free_head_q;
      free_head_q <= free_next;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      last_q   <= cmd_i.emit_last;
      if (cmd_i.emit_elem) begin
        item_q <= rd_value_q;
      end else if (cmd_i.emit_status == ST_EMPTY) begin
        item_q <= '0;
      end else begin
        item_q <= value_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign last_o      = last_q;

  always_comb begin
    stat_o.func      = func_q;
    stat_o.head_zero = (clamp_link(list_head_q) == '0);
    stat_o.next_zero = (next_link == '0);
    stat_o.less      = (rd_value_q < value_q);
    stat_o.equal     = (rd_value_q == value_q);
    stat_o.free_zero = (clamp_link(free_head_q) == '0);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // allocation only from a real free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr |-> (free_head_q != '0))
    else $error("allocation with empty free list");

  // list head and free head never name the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_head_q != '0) |-> (list_head_q != free_head_q))
    else $error("list head points into free list");

  // the free head only moves when a slot is spliced in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.link_wr) |-> $stable(free_head_q))
    else $error("free head moved without an insert");

endmodule

>>> design/sorted_array_linked_list_top.sv
// top level of the sorted linked list block
// joins sall_ctrl and sall_dp; uses sall_pkg
//
// keeps an ascending list of distinct signed 32-bit values threaded through
// SLOTS slots, slot 0 being the null link that never holds a value
// input channel (in_valid_i / in_ready_o): func_i 0 inserts value_i,
// func_i 1 dumps the list
// output channel (out_valid_o / out_ready_i): status_o, item_o, last_o
// an insert gives one result: inserted, duplicate or full (list unchanged)
// a dump gives one element result per stored value in ascending order,
// last_o on the final one, or a single empty result with item 0
// one item at a time: in_ready_o is high only while the controller is idle
// each insert step: one registered read of the slot memories, one compare
// the result sits in an output register, so a new item is taken the cycle
// after it is loaded, even while it waits; a stalled receiver holds the walk
// reset empties the list and starts the free chain at slot 1; no
// clearing pass is needed since free slots are handed out in order
module sorted_array_linked_list_top #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_o,
  output logic               last_o
);
  import sall_pkg::*;

  sall_cmd_t  cmd;
  sall_stat_t stat;

  // sequencer for walks, allocation and result ordering
  sall_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // slot memories, pointers and output register
  sall_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .item_o      (item_o),
    .last_o      (last_o)
  );

endmodule
